### src/its_pkg.sv
// Shared constants, codes and controller/datapath handshake types
// for the interval table search block. No dependencies.
package its_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);  // table address bits
    localparam int PTR_W       = IDX_W + 1;            // search bounds reach TABLE_DEPTH
    localparam int CNT_W       = 9;                    // entry_count register width
    localparam int TIME_W      = 64;
    localparam int SEG_W       = 8;                    // segment_index port width

    // operation field codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load_query;   // latch timestamp, lo = 0, hi = clamped count
        logic mem_write;    // store one entry from the input beat
        logic rd_search;    // read table at midpoint
        logic rd_walk;      // read table at lo - 1
        logic search_step;  // narrow bounds from registered start compare
        logic walk_step;    // lo = lo - 1
        logic set_hit;      // result = found at lo - 1
        logic set_miss;     // result = not found
        logic out_load;     // move result into output register
    } its_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic lo_lt_hi;
        logic lo_zero;
        logic hit;          // registered entry contains timestamp
    } its_sts_t;

endpackage

### src/its_ctrl.sv
// Sequencer for the interval table search: accepts beats, steps the
// binary search and backward walk, owns the output valid. Uses its_pkg.
module its_ctrl import its_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_operation,
    output logic     m_valid,
    input  logic     m_ready,
    input  its_sts_t sts,
    output its_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SRCH_RD  = 6'b000010,
        ST_SRCH_CMP = 6'b000100,
        ST_WALK_RD  = 6'b001000,
        ST_WALK_CMP = 6'b010000,
        ST_DONE     = 6'b100000
    } its_state_t;

    its_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == OP_WRITE) begin
                        cmd.mem_write = 1'b1;
                    end else begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD: begin
                if (sts.lo_lt_hi) begin
                    cmd.rd_search = 1'b1;
                    state_next    = ST_SRCH_CMP;
                end else begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_SRCH_CMP: begin
                cmd.search_step = 1'b1;
                state_next      = ST_SRCH_RD;
            end
            ST_WALK_RD: begin
                if (sts.lo_zero) begin
                    cmd.set_miss = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.rd_walk = 1'b1;
                    state_next  = ST_WALK_CMP;
                end
            end
            ST_WALK_CMP: begin
                if (sts.hit) begin
                    cmd.set_hit = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    cmd.walk_step = 1'b1;
                    state_next    = ST_WALK_RD;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### src/its_dp.sv
// Datapath for the interval table search: entry_count register, the
// start/end tables, search bounds, compares and result registers. Uses its_pkg.
module its_dp import its_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic [IDX_W-1:0]  s_entry_index,
    input  logic [TIME_W-1:0] s_start_time,
    input  logic [TIME_W-1:0] s_end_time,
    input  logic [TIME_W-1:0] s_timestamp,
    output logic              m_found,
    output logic [SEG_W-1:0]  m_segment_index,
    input  its_cmd_t          cmd,
    output its_sts_t          sts
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    logic [TIME_W-1:0] start_mem [TABLE_DEPTH];
    logic [TIME_W-1:0] end_mem   [TABLE_DEPTH];

    logic [CNT_W-1:0]  entry_count_reg;
    logic [TIME_W-1:0] ts_reg;
    logic [PTR_W-1:0]  lo_reg, lo_next;
    logic [PTR_W-1:0]  hi_reg, hi_next;
    logic [TIME_W-1:0] rd_start_reg;
    logic [TIME_W-1:0] rd_end_reg;
    logic              res_found_reg, res_found_next;
    logic [SEG_W-1:0]  res_seg_reg, res_seg_next;
    logic              out_found_reg;
    logic [SEG_W-1:0]  out_seg_reg;

    logic [PTR_W:0]    bound_sum;
    logic [IDX_W-1:0]  mid;
    logic [PTR_W-1:0]  lo_dec;
    logic [IDX_W-1:0]  rd_addr;
    logic [PTR_W-1:0]  count_clamped;
    logic              start_le;
    logic              end_ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_we) begin
            entry_count_reg <= cfg_wdata;
        end
    end

    // counts above the table depth behave as the full table
    assign count_clamped = (entry_count_reg > DEPTH_CNT) ? PTR_W'(TABLE_DEPTH)
                                                         : PTR_W'(entry_count_reg);

    // mid < hi <= TABLE_DEPTH, so it always fits an address
    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = bound_sum[IDX_W:1];
    assign lo_dec    = lo_reg - PTR_W'(1);
    assign rd_addr   = cmd.rd_search ? mid : lo_dec[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            start_mem[s_entry_index] <= s_start_time;
            end_mem[s_entry_index]   <= s_end_time;
        end
        if (cmd.rd_search || cmd.rd_walk) begin
            rd_start_reg <= start_mem[rd_addr];
            rd_end_reg   <= end_mem[rd_addr];
        end
    end

    assign start_le = (rd_start_reg <= ts_reg);
    assign end_ge   = (rd_end_reg >= ts_reg);

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.load_query) begin
            lo_next = '0;
            hi_next = count_clamped;
        end else if (cmd.search_step) begin
            if (start_le) begin
                lo_next = {1'b0, mid} + PTR_W'(1);
            end else begin
                hi_next = {1'b0, mid};
            end
        end else if (cmd.walk_step) begin
            lo_next = lo_dec;
        end
    end

    always_comb begin
        res_found_next = res_found_reg;
        res_seg_next   = res_seg_reg;
        if (cmd.set_hit) begin
            res_found_next = 1'b1;
            res_seg_next   = SEG_W'(lo_dec);
        end else if (cmd.set_miss) begin
            res_found_next = 1'b0;
            res_seg_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            ts_reg <= s_timestamp;
        end
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        res_found_reg <= res_found_next;
        res_seg_reg   <= res_seg_next;
        if (cmd.out_load) begin
            out_found_reg <= res_found_reg;
            out_seg_reg   <= res_seg_reg;
        end
    end

    assign sts.lo_lt_hi = (lo_reg < hi_reg);
    assign sts.lo_zero  = (lo_reg == '0);
    assign sts.hit      = start_le && end_ge;

    assign m_found         = out_found_reg;
    assign m_segment_index = out_seg_reg;

endmodule

### src/interval_table_search.sv
// Top level of the interval table search block: joins the sequencer
// (its_ctrl) and the datapath (its_dp). Uses its_pkg.
//
//  channel  direction  handshake          payload
//  s_*      in         s_valid/s_ready    operation, entry_index, start/end_time, timestamp
//  m_*      out        m_valid/m_ready    found, segment_index
//  cfg_*    in         cfg_we             cfg_wdata -> entry_count
//
// A write beat yields no result. A lookup beat runs a binary search (P probes, up to 9
// for a full 256-entry table), then walks back down from the search bound, W = entries
// read on the way back, until an entry contains the timestamp (a hit) or lo reaches
// zero (a miss); each probe or step is one read of the single-port table followed by a
// compare state, and the result then moves into the output register.
// Reset is synchronous on aresetn low: clears entry_count, state and m_valid;
// the table is not cleared. A finished result waiting on m_ready holds it; write
// beats are still taken meanwhile, a further lookup stalls before its output load.
module interval_table_search import its_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // input beats
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [IDX_W-1:0]  s_entry_index,
    input  logic [TIME_W-1:0] s_start_time,
    input  logic [TIME_W-1:0] s_end_time,
    input  logic [TIME_W-1:0] s_timestamp,
    // result beats
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [SEG_W-1:0]  m_segment_index,
    // entry_count register
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata
);

    its_cmd_t cmd;
    its_sts_t sts;

    // sequencer: one state per table read / compare
    its_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // tables, bounds, compares, output register
    its_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_entry_index   (s_entry_index),
        .s_start_time    (s_start_time),
        .s_end_time      (s_end_time),
        .s_timestamp     (s_timestamp),
        .m_found         (m_found),
        .m_segment_index (m_segment_index),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule
